// ----- rtl/csvt_pkg.sv -----
// package: shared types and character constants of the csv field tokenizer
`default_nettype none
package csvt_pkg;

   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_QUOTE  = 8'd34;
   localparam logic [7:0] CH_BSLASH = 8'd92;
   localparam logic [7:0] CH_N      = 8'd110;
   localparam logic [7:0] CH_T      = 8'd116;

   localparam logic [6:0] DELIM_RESET = 7'd44;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_DELIMITER = 1'b0;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // classified input byte
   typedef struct packed {
      logic [7:0] data;
      logic       eoi;
      logic       is_lf;
      logic       is_cr;
      logic       is_quote;
      logic       is_bslash;
      logic       is_delim;
   } tok_type;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic       record_end;
      logic [7:0] field_number;
      logic       stream_done;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/csvt_channels.sv -----
// interfaces: request and response channels of the csv field tokenizer
`default_nettype none
interface csvt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       field_end;
   logic       record_end;
   logic [7:0] field_number;
   logic       stream_done;

   modport source (output valid, output out_byte, output byte_valid, output field_end,
                   output record_end, output field_number, output stream_done,
                   input ready);
   modport sink (input valid, input out_byte, input byte_valid, input field_end,
                 input record_end, input field_number, input stream_done,
                 output ready);
endinterface
`default_nettype wire

// ----- rtl/csvt_front.sv -----
// front end: accepts raw bytes and classifies them into tokens
`default_nettype none
module csvt_front
   import csvt_pkg::*;
(
   csvt_req_if.sink  req_if,
   input  wire logic [6:0] delimiter,
   input  wire logic       queue_full,
   output logic            push,
   output tok_type         tok
);

   assign req_if.ready = !queue_full;
   assign push         = req_if.valid && !queue_full;

   always_comb begin
      tok.data      = req_if.in_byte;
      tok.eoi       = req_if.end_of_input;
      tok.is_lf     = (req_if.in_byte == CH_LF);
      tok.is_cr     = (req_if.in_byte == CH_CR);
      tok.is_quote  = (req_if.in_byte == CH_QUOTE);
      tok.is_bslash = (req_if.in_byte == CH_BSLASH);
      tok.is_delim  = (req_if.in_byte == {1'b0, delimiter});
   end

endmodule
`default_nettype wire

// ----- rtl/csvt_queue.sv -----
// token queue between front end and parser
`default_nettype none
module csvt_queue
   import csvt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire tok_type push_tok,
   input  wire logic    pop,
   output logic         full,
   output logic         nonempty,
   output tok_type      head_tok
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   tok_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head_tok = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/csvt_back.sv -----
// back end: csv parse state machine and result register
`default_nettype none
module csvt_back
   import csvt_pkg::*;
#(
   parameter int unsigned MAX_FIELDS = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    tok_avail,
   input  wire tok_type tok,
   output logic         pop,
   input  wire logic    rsp_ready,
   output logic         rsp_valid,
   output result_type   rsp_data
);

   localparam logic [7:0] FIELD_CAP =
      (MAX_FIELDS - 1 < 255) ? 8'(MAX_FIELDS - 1) : 8'd255;

   localparam logic [2:0] ST_BETWEEN    = 3'd0;
   localparam logic [2:0] ST_QUOTED     = 3'd1;
   localparam logic [2:0] ST_QUOTE_SEEN = 3'd2;
   localparam logic [2:0] ST_QUOTED_ESC = 3'd3;
   localparam logic [2:0] ST_SIMPLE     = 3'd4;
   localparam logic [2:0] ST_SIMPLE_ESC = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [7:0] field_ff, field_in;
   logic       has_field_ff, has_field_in;
   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   logic       give, fend, last, sdone;
   logic [7:0] gbyte, esc_byte;

   assign pop       = tok_avail && (!valid_ff || rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = res_ff;

   always_comb begin
      if (tok.data == CH_N) begin
         esc_byte = CH_LF;
      end else if (tok.data == CH_T) begin
         esc_byte = CH_TAB;
      end else begin
         esc_byte = tok.data;
      end
   end

   // one token step
   always_comb begin
      state_in = state_ff;
      give     = 1'b0;
      gbyte    = tok.data;
      fend     = 1'b0;
      last     = 1'b0;
      sdone    = 1'b0;
      case (state_ff)
         ST_QUOTED: begin
            if (tok.eoi) begin
               fend = 1'b1;
               last = 1'b1;
            end else if (tok.is_quote) begin
               state_in = ST_QUOTE_SEEN;
            end else if (tok.is_bslash) begin
               state_in = ST_QUOTED_ESC;
            end else begin
               give = 1'b1;
            end
         end
         ST_QUOTE_SEEN: begin
            if (tok.eoi || tok.is_lf) begin
               fend = 1'b1;
               last = 1'b1;
            end else if (tok.is_quote) begin
               state_in = ST_QUOTED;
               give     = 1'b1;
            end else if (tok.is_cr) begin
               state_in = ST_SIMPLE;
            end else if (tok.is_delim) begin
               fend = 1'b1;
            end else begin
               state_in = ST_SIMPLE;
               give     = 1'b1;
            end
         end
         ST_QUOTED_ESC: begin
            if (tok.eoi) begin
               fend = 1'b1;
               last = 1'b1;
            end else begin
               state_in = ST_QUOTED;
               give     = 1'b1;
               gbyte    = esc_byte;
            end
         end
         ST_SIMPLE: begin
            if (tok.eoi || tok.is_lf) begin
               fend = 1'b1;
               last = 1'b1;
            end else if (tok.is_cr) begin
               state_in = ST_SIMPLE;
            end else if (tok.is_bslash) begin
               state_in = ST_SIMPLE_ESC;
            end else if (tok.is_delim) begin
               fend = 1'b1;
            end else begin
               give = 1'b1;
            end
         end
         ST_SIMPLE_ESC: begin
            if (tok.eoi) begin
               fend = 1'b1;
               last = 1'b1;
            end else begin
               state_in = ST_SIMPLE;
               give     = 1'b1;
               gbyte    = esc_byte;
            end
         end
         default: begin
            // between fields, and unused codes
            state_in = ST_BETWEEN;
            if (tok.eoi) begin
               if (has_field_ff) begin
                  fend = 1'b1;
                  last = 1'b1;
               end else begin
                  sdone = 1'b1;
               end
            end else if (tok.is_lf) begin
               fend = 1'b1;
               last = 1'b1;
            end else if (tok.is_cr) begin
               state_in = ST_BETWEEN;
            end else if (tok.is_quote) begin
               state_in = ST_QUOTED;
            end else if (tok.is_bslash) begin
               state_in = ST_SIMPLE_ESC;
            end else if (tok.is_delim) begin
               fend = 1'b1;
            end else begin
               state_in = ST_SIMPLE;
               give     = 1'b1;
            end
         end
      endcase
      if (fend) begin
         state_in = ST_BETWEEN;
      end
   end

   always_comb begin
      field_in     = field_ff;
      has_field_in = has_field_ff;
      if (fend && last) begin
         field_in     = '0;
         has_field_in = 1'b0;
      end else if (fend) begin
         field_in     = (field_ff < FIELD_CAP) ? field_ff + 8'd1 : field_ff;
         has_field_in = 1'b1;
      end

      res_in.out_byte     = give ? gbyte : 8'd0;
      res_in.byte_valid   = give;
      res_in.field_end    = fend;
      res_in.record_end   = last;
      res_in.field_number = sdone ? 8'd0 : field_ff;
      res_in.stream_done  = sdone;

      valid_in = valid_ff;
      if (pop) begin
         valid_in = give || fend || sdone;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BETWEEN;
         field_ff     <= '0;
         has_field_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            state_ff     <= state_in;
            field_ff     <= field_in;
            has_field_ff <= has_field_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= res_in;
      end
   end

`ifndef ASSERT_OFF
   a_field_capped: assert property (@(posedge clock) disable iff (reset)
      field_ff <= FIELD_CAP)
      else $error("field index above cap");

   a_record_has_field_end: assert property (@(posedge clock) disable iff (reset)
      valid_ff && res_ff.record_end |-> res_ff.field_end)
      else $error("record end without field end");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> $onehot({res_ff.byte_valid, res_ff.field_end, res_ff.stream_done}))
      else $error("result carries no or several kinds");

   a_no_pop_when_stalled: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |-> !pop)
      else $error("token consumed while result stalled");

   a_state_reset_after_record: assert property (@(posedge clock) disable iff (reset)
      pop && fend && last |=> field_ff == 8'd0 && !has_field_ff)
      else $error("field index not cleared at record end");
`endif

endmodule
`default_nettype wire

// ----- rtl/csv_field_tokenizer.sv -----
// top level: csv field tokenizer with front end, token queue and parser
// usage:
//   req_if carries one raw byte (in_byte) or an end-of-input mark
//   (end_of_input) per transaction, valid/ready handshake
//   rsp_if carries one result per transaction: a decoded content byte, a
//   field end (with record end when the line or record closes), or a
//   stream-done mark; bytes that only steer the parser (quotes, escapes,
//   dropped carriage returns) give no transaction
//   csr_ port is an apb-style register port, delimiter at byte address 0
// timing:
//   one byte per cycle sustained while rsp_ready stays high; the parser state
//   machine steps once per cycle whenever the back end pops a token
//   a byte passes the token queue, then its result is held in the result register
// reset:
//   synchronous reset empties the queue, drops any pending result, sets
//   the parser between fields at field 0 and the delimiter back to comma
// stalls:
//   while rsp_ready is low a pending result in the result register holds; the queue keeps
//   taking bytes until it fills, then req_if.ready falls
`default_nettype none
module csv_field_tokenizer
   import csvt_pkg::*;
#(
   parameter int unsigned MAX_FIELDS = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   csvt_req_if.sink                   req_if,
   csvt_rsp_if.source                 rsp_if,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   // configuration register
   logic [6:0] delim_ff;
   logic       csr_wr;
   logic       csr_hit;

   // front to queue
   logic    push;
   tok_type push_tok;
   logic    q_full;

   // queue to back end
   logic       q_nonempty;
   logic       q_pop;
   tok_type    head_tok;
   result_type rsp_data;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == REG_DELIMITER) &&
                       (csr_paddr[CSR_ADDR_W-2:0] == '0);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_hit ? {25'd0, delim_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
      end else if (csr_wr && csr_hit) begin
         delim_ff <= csr_pwdata[6:0];
      end
   end

   // classify incoming bytes against the current delimiter
   csvt_front u_front (
      .req_if     (req_if),
      .delimiter  (delim_ff),
      .queue_full (q_full),
      .push       (push),
      .tok        (push_tok)
   );

   // short queue so front and back stall independently
   csvt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tok (push_tok),
      .pop      (q_pop),
      .full     (q_full),
      .nonempty (q_nonempty),
      .head_tok (head_tok)
   );

   // parse state machine and result register
   csvt_back #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_avail (q_nonempty),
      .tok       (head_tok),
      .pop       (q_pop),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_if.out_byte     = rsp_data.out_byte;
   assign rsp_if.byte_valid   = rsp_data.byte_valid;
   assign rsp_if.field_end    = rsp_data.field_end;
   assign rsp_if.record_end   = rsp_data.record_end;
   assign rsp_if.field_number = rsp_data.field_number;
   assign rsp_if.stream_done  = rsp_data.stream_done;

endmodule
`default_nettype wire
